[design/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and codes of the coordinate-list sparse matrix store.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam logic [2:0] ACT_READ  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_ACCUM = 3'd2;
    localparam logic [2:0] ACT_ROW   = 3'd3;
    localparam logic [2:0] ACT_COL   = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         row_index;
        logic [7:0]         col_index;
        logic signed [31:0] operand_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] element_value;
        logic               found;
        logic [7:0]         other_index;
        logic               status;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [31:0] val;
        logic [7:0]  row;
        logic [7:0]  col;
    } entry_t;

    // per-cycle command to the cell row
    typedef struct packed {
        logic rot;
        logic cmp;
        logic load;
    } cell_ctl_t;

endpackage

[design/smc_cell.sv]
// ----------------------------------------------------------------------------
// smc_cell
// One storage cell: rotates toward its neighbor, closes up on delete, or
// takes a new entry when it is the next free slot.
// ----------------------------------------------------------------------------
module smc_cell #(
    parameter int IDX = 0,
    parameter int PW  = 6,
    parameter int CW  = 7
) (
    input  logic              clk,
    input  smc_pkg::cell_ctl_t ctl,
    input  logic [PW-1:0]     pos,
    input  logic [CW-1:0]     cnt,
    input  smc_pkg::entry_t   nb,
    input  smc_pkg::entry_t   new_entry,
    output smc_pkg::entry_t   q
);

    smc_pkg::entry_t d_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rot)
        begin
            d_reg <= nb;
        end
        else if (ctl.cmp && (PW'(IDX) >= pos))
        begin
            d_reg <= nb;
        end
        else if (ctl.load && (CW'(IDX) == cnt))
        begin
            d_reg <= new_entry;
        end
    end

    assign q = d_reg;

endmodule

[design/sparse_matrix_coo_store.sv]
// Sparse matrix store in coordinate-list form. Entries sit in a ring of
// CAPACITY cells; every item rotates the ring once around, looking at one
// entry per cycle at the head while the rotation is not paused, then in a
// final step, once the output is free, delivers the result and applies an
// append or a close-up; no new item is taken before then. A row or column
// read pauses the rotation while a found word cannot be handed on.
// ----------------------------------------------------------------------------
// sparse_matrix_coo_store
// Top level: control sequencer, output register and the cell ring.
// ----------------------------------------------------------------------------
module sparse_matrix_coo_store #(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  smc_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output smc_pkg::out_word_t  out_data
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (INDEX_BITS < 8) ? INDEX_BITS : 8;
    localparam logic [7:0] IDX_MASK = 8'((1 << IW) - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

    state_t              state_reg;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       cnt_reg;
    logic [PW-1:0]       pos_reg;
    logic [2:0]          act_reg;
    logic [7:0]          r_reg;
    logic [7:0]          c_reg;
    logic [31:0]         v_reg;
    logic                found_reg;
    logic [31:0]         res_reg;
    logic                pend_v_reg;
    smc_pkg::out_word_t  pend_reg;
    logic                out_v_reg;
    smc_pkg::out_word_t  out_reg;

    smc_pkg::entry_t     cell_q [CAPACITY];
    smc_pkg::entry_t     nb     [CAPACITY];
    smc_pkg::entry_t     head;
    smc_pkg::entry_t     ring_in;
    smc_pkg::entry_t     new_entry;
    smc_pkg::cell_ctl_t  ctl;

    logic        is_list, is_row, is_upd;
    logic        live, hit_el, hit_ls, adv, out_free;
    logic [31:0] newval;
    logic        full, do_append, do_delete;
    logic        out_load;

    assign head     = cell_q[0];
    assign is_list  = (act_reg == smc_pkg::ACT_ROW) || (act_reg == smc_pkg::ACT_COL);
    assign is_row   = (act_reg == smc_pkg::ACT_ROW);
    assign is_upd   = (act_reg == smc_pkg::ACT_WRITE) || (act_reg == smc_pkg::ACT_ACCUM);
    assign live     = (k_reg < cnt_reg);
    assign hit_el   = live && !is_list && (head.row == r_reg) && (head.col == c_reg);
    assign hit_ls   = live && is_list && (is_row ? (head.row == r_reg) : (head.col == c_reg));
    assign newval   = (act_reg == smc_pkg::ACT_ACCUM) ? (head.val + v_reg) : v_reg;
    assign out_free = !out_v_reg || !out_stall;
    assign adv      = !(hit_ls && pend_v_reg && !out_free);

    // a word goes into the output register this cycle
    assign out_load = ((state_reg == S_SCAN) && adv && hit_ls && pend_v_reg)
                      || ((state_reg == S_FIN) && out_free);

    // element result actions at the end of the pass
    assign full      = !found_reg && is_upd && (res_reg != 32'd0)
                       && (cnt_reg == CW'(CAPACITY));
    assign do_append = !found_reg && is_upd && (res_reg != 32'd0) && !full;
    assign do_delete = found_reg && is_upd && (res_reg == 32'd0);

    always_comb
    begin
        ring_in = head;
        if (hit_el && is_upd)
        begin
            ring_in.val = newval;
        end
        new_entry.val = res_reg;
        new_entry.row = r_reg;
        new_entry.col = c_reg;
        ctl.rot  = (state_reg == S_SCAN) && adv;
        ctl.cmp  = (state_reg == S_FIN) && !is_list && out_free && do_delete;
        ctl.load = (state_reg == S_FIN) && !is_list && out_free && do_append;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign nb[gi] = ring_in;
            end
            else
            begin : g_mid
                assign nb[gi] = cell_q[gi + 1];
            end
            smc_cell #(.IDX(gi), .PW(PW), .CW(CW)) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .pos       (pos_reg),
                .cnt       (cnt_reg),
                .nb        (nb[gi]),
                .new_entry (new_entry),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            act_reg    <= smc_pkg::ACT_READ;
            r_reg      <= '0;
            c_reg      <= '0;
            v_reg      <= '0;
            found_reg  <= 1'b0;
            res_reg    <= '0;
            pend_v_reg <= 1'b0;
            pend_reg   <= '0;
            out_v_reg  <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        act_reg    <= in_data.action;
                        r_reg      <= in_data.row_index & IDX_MASK;
                        c_reg      <= in_data.col_index & IDX_MASK;
                        v_reg      <= in_data.operand_value;
                        found_reg  <= 1'b0;
                        // an absent element takes the operand on write or accumulate
                        res_reg    <= ((in_data.action == smc_pkg::ACT_WRITE)
                                       || (in_data.action == smc_pkg::ACT_ACCUM))
                                      ? in_data.operand_value : 32'd0;
                        pend_v_reg <= 1'b0;
                        k_reg      <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (adv)
                    begin
                        if (hit_el)
                        begin
                            found_reg <= 1'b1;
                            pos_reg   <= k_reg[PW-1:0];
                            res_reg   <= is_upd ? newval : head.val;
                        end
                        if (hit_ls)
                        begin
                            // previous hit is not the last one
                            if (pend_v_reg)
                            begin
                                out_reg <= pend_reg;
                            end
                            pend_v_reg             <= 1'b1;
                            pend_reg.element_value <= head.val;
                            pend_reg.found         <= 1'b1;
                            pend_reg.other_index   <= is_row ? head.col : head.row;
                            pend_reg.status        <= 1'b0;
                            pend_reg.last          <= 1'b0;
                        end
                        if (k_reg == CW'(CAPACITY - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        if (is_list)
                        begin
                            out_reg.element_value <= pend_v_reg ? pend_reg.element_value
                                                                : 32'sd0;
                            out_reg.found         <= pend_v_reg;
                            out_reg.other_index   <= pend_v_reg ? pend_reg.other_index
                                                                : 8'd0;
                            out_reg.status        <= 1'b0;
                            out_reg.last          <= 1'b1;
                            pend_v_reg <= 1'b0;
                        end
                        else
                        begin
                            out_reg.element_value <= full ? 32'sd0 : res_reg;
                            out_reg.found         <= found_reg;
                            out_reg.other_index   <= c_reg;
                            out_reg.status        <= full;
                            out_reg.last          <= 1'b1;
                            if (do_append)
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            else if (do_delete)
                            begin
                                cnt_reg <= cnt_reg - 1'b1;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_v_reg)
        else $error("pending list word left over in idle");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < CW'(CAPACITY)))
        else $error("scan ran past the ring");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FIN) |=> (cnt_reg == $past(cnt_reg)))
        else $error("entry count changed outside the final step");

endmodule
